// ===== rtl/fspa_pkg.sv =====
// Shared types, codes and constants of the fixed slot pool allocator.
package fspa_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int PADDR_W = 3;

    localparam logic [4:0]  ACTIVE_SLOTS_RESET = 5'd16;
    localparam logic [15:0] SLOT_SIZE_RESET    = 16'd1024;
    localparam logic [19:0] OFFSET_MAX         = 20'hFFFFF;

    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef enum logic {
        REG_ACTIVE_SLOTS = 1'b0,
        REG_SLOT_SIZE    = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RELEASE
    } state_t;

    typedef struct packed {
        logic       opcode;
        logic [7:0] release_slot;
    } cmd_t;

    typedef struct packed {
        logic        granted;
        logic [3:0]  granted_slot;
        logic [19:0] byte_offset;
        logic        freed;
        logic [4:0]  in_use_count;
        logic [4:0]  peak_in_use;
        logic [31:0] failed_acquires;
    } result_t;

    typedef struct packed {
        logic [4:0]  active_slots;
        logic [15:0] slot_size_bytes;
    } cfg_t;

endpackage

// ===== rtl/fspa_cfg.sv =====
// APB configuration registers of the fixed slot pool allocator.
module fspa_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fspa_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output fspa_pkg::cfg_t               cfg
);
    import fspa_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     wr_en;

    assign reg_idx = reg_idx_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_slots    <= ACTIVE_SLOTS_RESET;
            cfg_reg.slot_size_bytes <= SLOT_SIZE_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_ACTIVE_SLOTS: cfg_reg.active_slots    <= pwdata[4:0];
                REG_SLOT_SIZE:    cfg_reg.slot_size_bytes <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_ACTIVE_SLOTS: prdata = {27'b0, cfg_reg.active_slots};
            REG_SLOT_SIZE:    prdata = {16'b0, cfg_reg.slot_size_bytes};
            default:          prdata = 32'b0;
        endcase
    end

endmodule

// ===== rtl/fspa_engine.sv =====
// Scan sequencer, used-slot map, offset accumulator and counters of the allocator.
module fspa_engine #(
    parameter int NUM_SLOTS = fspa_pkg::NUM_SLOTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  fspa_pkg::cfg_t    cfg,
    input  logic              start,
    input  fspa_pkg::cmd_t    cmd,
    output logic              busy,
    output logic              done,
    output fspa_pkg::result_t result
);
    import fspa_pkg::*;

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam int ACC_W  = SLOT_W + 16;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     idx_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic                 rel_ok_reg;
    logic                 used_reg [NUM_SLOTS];
    logic [CNT_W-1:0]     held_reg, held_next;
    logic [CNT_W-1:0]     peak_reg, peak_next;
    logic [31:0]          fail_reg, fail_next;
    result_t              result_reg;
    logic                 done_reg;

    logic [CNT_W-1:0]     limit;
    logic [SLOT_W-1:0]    slot_idx;
    logic                 used_bit;
    logic                 in_range;
    logic                 grant;
    logic                 fail;
    logic                 free;
    logic                 emit;
    logic [19:0]          offset_sat;

    assign limit    = (32'(cfg.active_slots) > NUM_SLOTS) ? CNT_W'(NUM_SLOTS)
                                                         : CNT_W'(cfg.active_slots);
    assign slot_idx = idx_reg[SLOT_W-1:0];
    assign used_bit = used_reg[slot_idx];
    assign in_range = idx_reg < limit;
    assign offset_sat = (32'(acc_reg) > 32'(OFFSET_MAX)) ? OFFSET_MAX : 20'(acc_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (cmd.opcode == OP_ACQUIRE) ? ST_SCAN : ST_RELEASE;
                end
            end
            ST_SCAN:
            begin
                if (!in_range || !used_bit)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RELEASE: state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        grant = 1'b0;
        fail  = 1'b0;
        free  = 1'b0;
        emit  = 1'b0;
        case (state_reg)
            ST_SCAN:
            begin
                grant = in_range && !used_bit;
                fail  = !in_range;
                emit  = !in_range || !used_bit;
            end
            ST_RELEASE:
            begin
                free = rel_ok_reg && used_bit;
                emit = 1'b1;
            end
            default: ;
        endcase
        held_next = held_reg + CNT_W'(grant) - CNT_W'(free);
        peak_next = (grant && (held_next > peak_reg)) ? held_next : peak_reg;
        fail_next = fail_reg + 32'(fail);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            held_reg  <= '0;
            peak_reg  <= '0;
            fail_reg  <= '0;
            done_reg  <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                used_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            held_reg  <= held_next;
            peak_reg  <= peak_next;
            fail_reg  <= fail_next;
            done_reg  <= emit;
            if (grant)
            begin
                used_reg[slot_idx] <= 1'b1;
            end
            else if (free)
            begin
                used_reg[slot_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            acc_reg    <= '0;
            rel_ok_reg <= 32'(cmd.release_slot) < 32'(limit);
            idx_reg    <= (cmd.opcode == OP_ACQUIRE) ? '0 : CNT_W'(cmd.release_slot);
        end
        else if (state_reg == ST_SCAN && in_range && used_bit)
        begin
            idx_reg <= idx_reg + CNT_W'(1);
            acc_reg <= acc_reg + ACC_W'(cfg.slot_size_bytes);
        end
        if (emit)
        begin
            result_reg.granted         <= grant;
            result_reg.granted_slot    <= grant ? 4'(idx_reg) : 4'd0;
            result_reg.byte_offset     <= grant ? offset_sat : 20'd0;
            result_reg.freed           <= free;
            result_reg.in_use_count    <= 5'(held_next);
            result_reg.peak_in_use     <= 5'(peak_next);
            result_reg.failed_acquires <= fail_next;
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/fixed_slot_pool_allocator.sv =====
// Top level of the fixed slot pool allocator: configuration port and scan engine.
// An acquire scans the used bits from slot 0 up and grants the first free slot. A failed
// acquire scans every usable slot (the active count, at most NUM_SLOTS); a release tests one.
// The scan tests one used bit per cycle, and busy stays high until the result is shown,
// so the next transaction is accepted at the earliest at the edge that ends the result cycle.
// The result is shown for one cycle with done and cannot be stalled by the receiver.
// Reset clears the used map and all counters and loads the register defaults.
module fixed_slot_pool_allocator #(
    parameter int NUM_SLOTS = fspa_pkg::NUM_SLOTS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fspa_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         start,
    input  fspa_pkg::cmd_t               cmd,
    output logic                         busy,
    output logic                         done,
    output fspa_pkg::result_t            result
);
    import fspa_pkg::*;

    cfg_t cfg;

    fspa_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fspa_engine #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not make the block busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result delivered while a transaction is still in progress");

    a_grant_free_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.granted && result.freed))
        else $error("result reports both a grant and a free");

    a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.granted |-> result.granted_slot == 4'd0 && result.byte_offset == 20'd0)
        else $error("slot or offset reported without a grant");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the fixed slot pool allocator, with a slot map scoreboard.
import fspa_pkg::*;

class pool_scoreboard;
    logic [NUM_SLOTS_DEF-1:0] slot_used;
    int unsigned held;
    int unsigned peak;
    logic [31:0] fails;
    logic [4:0] active_slots;
    logic [15:0] slot_size;
    result_t pending[$];
    int errors;

    function new();
        slot_used = '0;
        held = 0;
        peak = 0;
        fails = '0;
        active_slots = ACTIVE_SLOTS_RESET;
        slot_size = SLOT_SIZE_RESET;
        errors = 0;
    endfunction

    function void set_register(reg_idx_t idx, logic [31:0] val);
        if (idx == REG_ACTIVE_SLOTS)
            active_slots = val[4:0];
        else
            slot_size = val[15:0];
    endfunction

    function void note_command(cmd_t c);
        result_t r;
        int unsigned lim;
        logic [31:0] off;
        r = '0;
        lim = (active_slots > NUM_SLOTS_DEF) ? NUM_SLOTS_DEF : active_slots;
        if (c.opcode == OP_ACQUIRE)
        begin
            for (int s = 0; s < lim && !r.granted; s++)
            begin
                if (!slot_used[s])
                begin
                    slot_used[s] = 1'b1;
                    held++;
                    if (held > peak)
                        peak = held;
                    off = s * slot_size;
                    r.granted = 1'b1;
                    r.granted_slot = s[3:0];
                    r.byte_offset = (off > OFFSET_MAX) ? OFFSET_MAX : off[19:0];
                end
            end
            if (!r.granted)
                fails = fails + 1;
        end
        else if (c.release_slot < lim && slot_used[c.release_slot])
        begin
            slot_used[c.release_slot] = 1'b0;
            if (held > 0)
                held--;
            r.freed = 1'b1;
        end
        r.in_use_count = held[4:0];
        r.peak_in_use = peak[4:0];
        r.failed_acquires = fails;
        pending.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (act_val !== exp_val)
        begin
            $display("%0t: mismatch on %s, expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
            errors++;
        end
    endfunction

    function void check_result(result_t act);
        result_t exp_r;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected transaction, expected none, actual %h", $time, act);
            errors++;
            return;
        end
        exp_r = pending.pop_front();
        compare_field("granted", 32'(exp_r.granted), 32'(act.granted));
        compare_field("granted_slot", 32'(exp_r.granted_slot), 32'(act.granted_slot));
        compare_field("byte_offset", 32'(exp_r.byte_offset), 32'(act.byte_offset));
        compare_field("freed", 32'(exp_r.freed), 32'(act.freed));
        compare_field("in_use_count", 32'(exp_r.in_use_count), 32'(act.in_use_count));
        compare_field("peak_in_use", 32'(exp_r.peak_in_use), 32'(act.peak_in_use));
        compare_field("failed_acquires", exp_r.failed_acquires, act.failed_acquires);
    endfunction
endclass

module testbench;
    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    logic start;
    cmd_t cmd;
    logic busy;
    logic done;
    result_t result;

    pool_scoreboard sb = new();

    fixed_slot_pool_allocator i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .start   (start),
        .cmd     (cmd),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(12 * 800000);
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    task automatic do_op(input logic op, input logic [7:0] slot);
        cmd_t c;
        c.opcode = op;
        c.release_slot = slot;
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_command(c);
    endtask

    task automatic acquire();
        do_op(OP_ACQUIRE, 8'($urandom_range(0, 255)));
    endtask

    task automatic pause(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        while (busy)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        logic [31:0] exp_val;
        exp_val = (idx == REG_ACTIVE_SLOTS) ? {27'd0, val[4:0]} : {16'd0, val[15:0]};
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(int'(idx) * 4);
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_register(idx, val);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== exp_val)
        begin
            $display("%0t: register readback mismatch, expected %0d, actual %0d",
                     $time, exp_val, prdata);
            sb.errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [31:0] act_val, input logic [31:0] size_val);
        drain();
        if ($urandom_range(0, 1))
        begin
            write_reg(REG_ACTIVE_SLOTS, act_val);
            write_reg(REG_SLOT_SIZE, size_val);
        end
        else
        begin
            write_reg(REG_SLOT_SIZE, size_val);
            write_reg(REG_ACTIVE_SLOTS, act_val);
        end
    endtask

    initial
    begin
        int n_items;
        int acq_pct;
        int lim;
        int pick;
        logic [31:0] act_val;
        logic [31:0] size_val;
        logic [7:0] slot;

        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        start <= 1'b0;
        cmd <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: grants, a real free, frees of a free slot and out of range.
        repeat (3) acquire();
        do_op(OP_RELEASE, 8'd1);
        do_op(OP_RELEASE, 8'd1);
        do_op(OP_RELEASE, 8'd255);
        do_op(OP_RELEASE, 8'd16);
        acquire();

        // Lowered active count while slot 2 stays held above it.
        configure(32'd2, 32'd65535);
        acquire();
        do_op(OP_RELEASE, 8'd2);
        do_op(OP_RELEASE, 8'd0);
        acquire();

        // No usable slot and zero slot size.
        configure(32'd0, 32'd0);
        acquire();
        do_op(OP_RELEASE, 8'd0);

        // Active count above the built size, largest slot size, pool filled past full.
        configure(32'd31, 32'hFFFF_FFFF);
        repeat (14) acquire();
        do_op(OP_RELEASE, 8'd15);
        do_op(OP_RELEASE, 8'd0);

        for (int p = 0; p < 10; p++)
        begin
            case (p)
                0: begin act_val = 32'd16; size_val = 32'd1024; end
                1: begin act_val = 32'd1; size_val = 32'd1; end
                2: begin act_val = 32'd31; size_val = 32'd65535; end
                3: begin act_val = 32'd0; size_val = 32'd0; end
                default: begin act_val = $urandom; size_val = $urandom; end
            endcase
            configure(act_val, size_val);
            lim = (act_val[4:0] > NUM_SLOTS_DEF) ? NUM_SLOTS_DEF : act_val[4:0];
            n_items = (p == 3) ? 40 : 220;
            acq_pct = $urandom_range(35, 65);
            for (int i = 0; i < n_items; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < acq_pct)
                begin
                    acquire();
                end
                else
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 60)
                        slot = 8'($urandom_range(0, (lim > 0) ? lim - 1 : 0));
                    else if (pick < 85)
                        slot = 8'($urandom_range(0, NUM_SLOTS_DEF - 1));
                    else
                        slot = 8'($urandom_range(0, 255));
                    do_op(OP_RELEASE, slot);
                end
                if (p == 5 && i == n_items / 2)
                    drain();
                else if (p != 4 && $urandom_range(0, 99) < 27)
                    pause($urandom_range(1, 20));
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
